### rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while in reset
`define ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, sampled on clk, off while in reset
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### rtl/fcwd_pkg.sv
// Package: types, codes and defaults for the front coding word decoder
`timescale 1ns / 1ps

package fcwd_pkg;

    localparam int BYTE_W       = 8;
    localparam int WORD_CAP_DEF = 63;

    typedef enum logic [1:0] {
        KIND_CHAR     = 2'd0,
        KIND_END      = 2'd1,
        KIND_BAD_TRIM = 2'd2,
        KIND_OVERFLOW = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_CHAR,
        ST_END,
        ST_ERR,
        ST_HALT
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic  trim;
        logic  append;
        logic  rd_start;
        logic  rd_en;
        logic  rd_next;
        logic  set_expect;
        kind_t out_kind;
        logic  out_last;
    } fcwd_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic expect_trim;
        logic trim_bad;
        logic full;
        logic byte_zero;
        logic len_zero;
        logic rd_last;
    } fcwd_status_t;

endpackage

### rtl/fcwd_ifs.sv
// Stream interfaces: input byte channel and result channel
`timescale 1ns / 1ps

interface fcwd_in_if;
    import fcwd_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface fcwd_out_if;
    import fcwd_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_char;
    logic [1:0]        kind;
    logic              last;

    modport source (output valid, output out_char, output kind, output last, input ready);
    modport sink   (input valid, input out_char, input kind, input last, output ready);
endinterface

### rtl/front_coding_word_decoder_unit.sv
// Top level of the front coding word decoder
// Trim and suffix bytes: taken with no result beat.
// Bad trim or overflow: error beat valid the cycle after the byte, then halt until reset.
// Terminator: each character is read from the registered store, then given as a character
// beat (stall on out_ready); then the end-of-word beat, which an empty word gives alone.
// Reset (async, low): length zero, trim expected, not halted; store contents kept.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module front_coding_word_decoder_unit #(
    parameter int WORD_CAP = fcwd_pkg::WORD_CAP_DEF
) (
    input logic         clk,
    input logic         rst_n,
    fcwd_in_if.sink     in_stream,
    fcwd_out_if.source  out_stream
);
    import fcwd_pkg::*;

    fcwd_cmd_t         cmd;
    fcwd_status_t      status;
    logic              in_ready;
    logic              out_valid;
    logic [BYTE_W-1:0] out_char;
    kind_t             out_kind;
    logic              out_last;

    fcwd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_stream.valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_stream.ready),
        .status    (status),
        .cmd       (cmd)
    );

    fcwd_datapath #(
        .WORD_CAP (WORD_CAP)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_byte  (in_stream.in_byte),
        .cmd      (cmd),
        .status   (status),
        .out_char (out_char),
        .kind     (out_kind),
        .last     (out_last)
    );

    assign in_stream.ready   = in_ready;
    assign out_stream.valid  = out_valid;
    assign out_stream.out_char = out_char;
    assign out_stream.kind   = out_kind;
    assign out_stream.last   = out_last;

    // a character beat is never the final beat of a byte
    `ASSERT_NOW(a_char_not_last, out_valid && (out_kind == KIND_CHAR), !out_last)
    // input and output sides are never open at once
    `ASSERT_NOW(a_in_out_exclusive, in_ready, !out_valid)
    // store never written at capacity
    `ASSERT_NOW(a_no_write_when_full, cmd.append, !status.full)
    // each store read is followed by a character beat
    `ASSERT_NEXT(a_read_then_char, cmd.rd_en, out_valid && (out_kind == KIND_CHAR))

endmodule

### rtl/fcwd_ctrl.sv
// Controller: sequences trim, append, word read-out and error beats
`timescale 1ns / 1ps

module fcwd_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    input  fcwd_pkg::fcwd_status_t status,
    output fcwd_pkg::fcwd_cmd_t    cmd
);
    import fcwd_pkg::*;

    state_t state_reg, state_next;
    kind_t  err_kind_reg, err_kind_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            err_kind_reg <= KIND_BAD_TRIM;
        end
        else
        begin
            state_reg    <= state_next;
            err_kind_reg <= err_kind_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        err_kind_next = err_kind_reg;
        cmd           = '0;
        cmd.out_kind  = KIND_CHAR;
        in_ready      = 1'b0;
        out_valid     = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (status.expect_trim)
                    begin
                        if (status.trim_bad)
                        begin
                            err_kind_next = KIND_BAD_TRIM;
                            state_next    = ST_ERR;
                        end
                        else
                        begin
                            cmd.trim = 1'b1;
                        end
                    end
                    else if (!status.byte_zero)
                    begin
                        if (status.full)
                        begin
                            err_kind_next = KIND_OVERFLOW;
                            state_next    = ST_ERR;
                        end
                        else
                        begin
                            cmd.append = 1'b1;
                        end
                    end
                    else
                    begin
                        cmd.rd_start = 1'b1;
                        state_next   = status.len_zero ? ST_END : ST_READ;
                    end
                end
            end

            ST_READ:
            begin
                cmd.rd_en  = 1'b1;
                state_next = ST_CHAR;
            end

            ST_CHAR:
            begin
                out_valid    = 1'b1;
                cmd.out_kind = KIND_CHAR;
                if (out_ready)
                begin
                    if (status.rd_last)
                    begin
                        state_next = ST_END;
                    end
                    else
                    begin
                        cmd.rd_next = 1'b1;
                        state_next  = ST_READ;
                    end
                end
            end

            ST_END:
            begin
                out_valid    = 1'b1;
                cmd.out_kind = KIND_END;
                cmd.out_last = 1'b1;
                if (out_ready)
                begin
                    cmd.set_expect = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            ST_ERR:
            begin
                out_valid    = 1'b1;
                cmd.out_kind = err_kind_reg;
                cmd.out_last = 1'b1;
                if (out_ready)
                begin
                    state_next = ST_HALT;
                end
            end

            ST_HALT:
            begin
                // bytes are taken and dropped until reset
                in_ready = 1'b1;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### rtl/fcwd_datapath.sv
// Datapath: word store, length, read pointer and result payload
`timescale 1ns / 1ps

module fcwd_datapath #(
    parameter int WORD_CAP = fcwd_pkg::WORD_CAP_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [fcwd_pkg::BYTE_W-1:0] in_byte,
    input  fcwd_pkg::fcwd_cmd_t         cmd,
    output fcwd_pkg::fcwd_status_t      status,
    output logic [fcwd_pkg::BYTE_W-1:0] out_char,
    output fcwd_pkg::kind_t             kind,
    output logic                        last
);
    import fcwd_pkg::*;

    localparam int IDX_W = (WORD_CAP > 1) ? $clog2(WORD_CAP) : 1;
    localparam int LEN_W = $clog2(WORD_CAP + 1);

    logic [BYTE_W-1:0] word_store [WORD_CAP];
    logic [BYTE_W-1:0] rd_data_reg;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [IDX_W-1:0]  rd_idx_reg, rd_idx_next;
    logic              expect_reg, expect_next;

    always_comb
    begin
        len_next    = len_reg;
        rd_idx_next = rd_idx_reg;
        expect_next = expect_reg;
        if (cmd.trim)
        begin
            len_next    = len_reg - LEN_W'(in_byte);
            expect_next = 1'b0;
        end
        if (cmd.append)
        begin
            len_next = len_reg + LEN_W'(1);
        end
        if (cmd.set_expect)
        begin
            expect_next = 1'b1;
        end
        if (cmd.rd_start)
        begin
            rd_idx_next = '0;
        end
        if (cmd.rd_next)
        begin
            rd_idx_next = rd_idx_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg    <= '0;
            rd_idx_reg <= '0;
            expect_reg <= 1'b1;
        end
        else
        begin
            len_reg    <= len_next;
            rd_idx_reg <= rd_idx_next;
            expect_reg <= expect_next;
        end
    end

    // store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.append)
        begin
            word_store[len_reg[IDX_W-1:0]] <= in_byte;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= word_store[rd_idx_reg];
        end
    end

    always_comb
    begin
        status.expect_trim = expect_reg;
        status.trim_bad    = in_byte > BYTE_W'(len_reg);
        status.full        = len_reg == LEN_W'(WORD_CAP);
        status.byte_zero   = in_byte == '0;
        status.len_zero    = len_reg == '0;
        status.rd_last     = (LEN_W'(rd_idx_reg) + LEN_W'(1)) == len_reg;
    end

    assign out_char = (cmd.out_kind == KIND_CHAR) ? rd_data_reg : '0;
    assign kind     = cmd.out_kind;
    assign last     = cmd.out_last;

endmodule
